// ===== design/exon_alignment_gap_classifier_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef EXON_ALIGNMENT_GAP_CLASSIFIER_DEFINES_SVH
`define EXON_ALIGNMENT_GAP_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EAGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eagc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EAGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eagc assertion failed");

`endif

// ===== design/eagc_pkg.sv =====
`default_nettype none
package eagc_pkg;

  typedef enum logic [2:0] {
    VERDICT_HAS_N     = 3'd0,
    VERDICT_NO_GAPS   = 3'd1,
    VERDICT_BAD_GAP   = 3'd2,
    VERDICT_GAPS_OK   = 3'd3,
    VERDICT_NOT_FOUND = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    CFG_EXON_BEGIN  = 2'd0,
    CFG_EXON_END    = 2'd1,
    CFG_ALIGN_START = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] GAP_CHAR     = 8'h2D;
  localparam logic [7:0] UPPER_N_CHAR = 8'h4E;
  localparam logic [7:0] LOWER_N_CHAR = 8'h6E;
  localparam logic [1:0] RUN_MOD_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] run_mod;
    logic       in_run;
  } run_t;

  // One column of a gap run tracker; the length is kept modulo three.
  function automatic run_t run_next(run_t cur, logic is_gap);
    run_t nxt;
    if (is_gap) begin
      nxt.run_mod = (cur.run_mod == RUN_MOD_LAST) ? 2'd0 : cur.run_mod + 2'd1;
      nxt.in_run  = 1'b1;
    end else begin
      nxt.run_mod = 2'd0;
      nxt.in_run  = 1'b0;
    end
    return nxt;
  endfunction

  // A run that ends with a length not a multiple of three.
  function automatic logic run_bad(run_t cur);
    return cur.in_run && (cur.run_mod != 2'd0);
  endfunction

endpackage
`default_nettype wire

// ===== design/exon_alignment_gap_classifier.sv =====
`default_nettype none
// Classifies the gap pattern of an exon window in a pairwise alignment, one
// column per clock cycle unless out_tready stalls the output. A column transfer
// on the input is held in an input register and evaluated against the window
// state; the verdict for the column that closes the window (or for the last
// column when the window never closed) lands in the output register. The output
// register lets the next column be taken while a verdict waits; in_tready follows
// out_tready only when both registers are full. The user must write registers
// through the cfg port only while the stream is idle (not enforced here); a
// write of align_start also reloads the reference position counter.
module exon_alignment_gap_classifier
  import eagc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // ref_char [7:0], other_char [15:8]
  input  wire logic        in_tlast,   // last_column
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // verdict [2:0], zero [7:3]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] exon_begin_r;
  logic [31:0] exon_end_r;
  logic [31:0] align_start_r;

  logic        s1_valid_r;
  logic [7:0]  ref_char_r;
  logic [7:0]  other_char_r;
  logic        last_r;

  logic [31:0] pos_r, pos_nxt;
  logic        open_r, open_nxt;
  logic        done_r, done_nxt;
  logic        saw_gap_r, saw_gap_nxt;
  logic        saw_n_r, saw_n_nxt;
  logic        bad_gap_r, bad_gap_nxt;
  run_t        ref_run_r, ref_run_nxt;
  run_t        oth_run_r, oth_run_nxt;

  logic        out_valid_r;
  verdict_t    verdict_r;

  logic        out_free;
  logic        s1_fire;
  logic        emit;
  verdict_t    verdict_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, verdict_r};

  always_comb begin
    logic ref_gap;
    logic oth_gap;
    logic has_n;
    logic take;
    logic open_now;
    ref_gap      = (ref_char_r == GAP_CHAR);
    oth_gap      = (other_char_r == GAP_CHAR);
    has_n        = (ref_char_r == UPPER_N_CHAR) || (ref_char_r == LOWER_N_CHAR) ||
                   (other_char_r == UPPER_N_CHAR) || (other_char_r == LOWER_N_CHAR);
    take         = 1'b0;
    open_now     = open_r;
    pos_nxt      = pos_r;
    open_nxt     = open_r;
    done_nxt     = done_r;
    saw_gap_nxt  = saw_gap_r;
    saw_n_nxt    = saw_n_r;
    bad_gap_nxt  = bad_gap_r;
    ref_run_nxt  = ref_run_r;
    oth_run_nxt  = oth_run_r;
    emit         = 1'b0;
    verdict_nxt  = VERDICT_NOT_FOUND;

    if (s1_fire) begin
      if (!done_r) begin
        if (!ref_gap) begin
          pos_nxt = pos_r + 32'd1;
          if (pos_r == exon_end_r) begin
            emit     = 1'b1;
            open_nxt = 1'b0;
            done_nxt = 1'b1;
            if (open_r) begin
              if (saw_n_r) begin
                verdict_nxt = VERDICT_HAS_N;
              end else if (!saw_gap_r) begin
                verdict_nxt = VERDICT_NO_GAPS;
              end else if (bad_gap_r || run_bad(ref_run_r) || run_bad(oth_run_r)) begin
                verdict_nxt = VERDICT_BAD_GAP;
              end else begin
                verdict_nxt = VERDICT_GAPS_OK;
              end
            end else if (pos_r == exon_begin_r) begin
              verdict_nxt = VERDICT_NO_GAPS;
            end else begin
              verdict_nxt = VERDICT_NOT_FOUND;
            end
          end else begin
            open_now = open_r || (pos_r == exon_begin_r);
            open_nxt = open_now;
            take     = open_now;
          end
        end else begin
          take = open_r;
        end
      end

      if (take) begin
        saw_n_nxt   = saw_n_r || has_n;
        saw_gap_nxt = saw_gap_r || ref_gap || oth_gap;
        bad_gap_nxt = bad_gap_r || (!ref_gap && run_bad(ref_run_r)) ||
                      (!oth_gap && run_bad(oth_run_r));
        ref_run_nxt = run_next(ref_run_r, ref_gap);
        oth_run_nxt = run_next(oth_run_r, oth_gap);
      end

      if (last_r) begin
        if (!done_nxt) begin
          emit        = 1'b1;
          verdict_nxt = VERDICT_NOT_FOUND;
        end
        pos_nxt     = align_start_r;
        open_nxt    = 1'b0;
        done_nxt    = 1'b0;
        saw_gap_nxt = 1'b0;
        saw_n_nxt   = 1'b0;
        bad_gap_nxt = 1'b0;
        ref_run_nxt = '0;
        oth_run_nxt = '0;
      end
    end

    if (cfg_we && (cfg_index == CFG_ALIGN_START)) begin
      pos_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exon_begin_r  <= '0;
      exon_end_r    <= '0;
      align_start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXON_BEGIN:  exon_begin_r  <= cfg_wdata;
        CFG_EXON_END:    exon_end_r    <= cfg_wdata;
        CFG_ALIGN_START: align_start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ref_char_r   <= in_tdata[7:0];
      other_char_r <= in_tdata[15:8];
      last_r       <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      open_r    <= 1'b0;
      done_r    <= 1'b0;
      saw_gap_r <= 1'b0;
      saw_n_r   <= 1'b0;
      bad_gap_r <= 1'b0;
      ref_run_r <= '0;
      oth_run_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      open_r    <= open_nxt;
      done_r    <= done_nxt;
      saw_gap_r <= saw_gap_nxt;
      saw_n_r   <= saw_n_nxt;
      bad_gap_r <= bad_gap_nxt;
      ref_run_r <= ref_run_nxt;
      oth_run_r <= oth_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      verdict_r <= verdict_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/eagc_checker.sv =====
`default_nettype none
`include "exon_alignment_gap_classifier_defines.svh"
module eagc_checker
  import eagc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  logic verdict_legal;

  assign verdict_legal = (out_tdata[7:3] == 5'd0) &&
                         (out_tdata[2:0] <= VERDICT_NOT_FOUND);

  // A stalled result must hold until its transfer.
  `EAGC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Every verdict is one of the defined codes.
  `EAGC_ASSERT_NOW(a_verdict_legal, out_tvalid, verdict_legal)
  // With the output register empty, the input side can never be blocked.
  `EAGC_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready)

endmodule

bind exon_alignment_gap_classifier eagc_checker u_eagc_checker (.*);
`default_nettype wire
